/* src/cfnr_pkg.sv */
`timescale 1ns / 1ps

package cfnr_pkg;

   localparam int COUNT_BITS = 19;
   localparam int CSR_DATA_BITS = COUNT_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIDIR_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSFER_COUNT = 1'd1;

   localparam logic [COUNT_BITS-1:0] TRANSFER_COUNT_RESET = COUNT_BITS'(57600);

   localparam logic [7:0] PAD_BYTE = 8'h7e;
   localparam logic [7:0] EOF_BYTE0 = 8'h0e;
   localparam logic [7:0] EOF_BYTE1 = 8'h00;
   localparam logic [7:0] EOF_BYTE2 = 8'h0f;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RECV = 2'd1,
      ST_DONE = 2'd2,
      ST_FAIL = 2'd3
   } stage_type;

   typedef struct packed {
      logic       command;
      logic [7:0] port_data;
      logic [7:0] port_status;
   } req_type;

   typedef struct packed {
      logic       ack_level;
      logic [1:0] byte_count;
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [1:0] frame_status;
   } rsp_type;

   // classified word passed from front to back
   typedef struct packed {
      logic       start;
      logic       nib_ready;
      logic       bid_ready;
      logic [7:0] port_data;
      logic [7:0] port_status;
   } work_type;

   typedef struct packed {
      logic bidir_mode;
      logic [COUNT_BITS-1:0] transfer_count;
   } cfg_type;

   function automatic stage_type marker_check(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
      return (b0 == EOF_BYTE0 && b1 == EOF_BYTE1 && b2 == EOF_BYTE2) ? ST_DONE : ST_FAIL;
   endfunction

endpackage

/* src/cfnr_front.sv */
`timescale 1ns / 1ps

module cfnr_front (
   input  cfnr_pkg::req_type  req_item,
   output cfnr_pkg::work_type work
);

   always_comb begin
      work.start       = req_item.command;
      work.nib_ready   = req_item.port_status[3];
      work.bid_ready   = req_item.port_data[0];
      work.port_data   = req_item.port_data;
      work.port_status = req_item.port_status;
   end

endmodule

/* src/cfnr_queue.sv */
`timescale 1ns / 1ps

module cfnr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfnr_pkg::work_type push_word,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output cfnr_pkg::work_type pop_word
);

   cfnr_pkg::work_type                  mem_ff [cfnr_pkg::QUEUE_DEPTH];
   logic [cfnr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfnr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfnr_pkg::QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full      = (cnt_ff == cfnr_pkg::QUEUE_CNT_BITS'(cfnr_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* src/cfnr_back.sv */
`timescale 1ns / 1ps

module cfnr_back (
   input  logic               clock,
   input  logic               reset,
   input  cfnr_pkg::cfg_type  cfg,
   input  logic               work_valid,
   input  cfnr_pkg::work_type work,
   output logic               work_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cfnr_pkg::rsp_type  rsp_item
);

   cfnr_pkg::stage_type             stage_ff, stage_in;
   logic                            second_half_ff, second_half_in;
   logic                            ack_ff, ack_in;
   logic [cfnr_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic [11:0]                     held_ff, held_in;
   logic [15:0]                     tail_ff, tail_in;
   logic [1:0]                      tail_idx_ff, tail_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cfnr_pkg::rsp_type               rsp_ff, rsp_in;

   logic       step;
   logic       ready_now;
   logic       take_first;
   logic       complete;
   logic       pixel;
   logic [7:0] b0, b1, b2;
   logic [4:0] hi2;

   assign work_pop  = work_valid && (!rsp_valid_ff || !rsp_stall);
   assign step      = work_pop && !work.start && (stage_ff == cfnr_pkg::ST_RECV);
   assign ready_now = cfg.bidir_mode ? work.bid_ready : work.nib_ready;
   assign take_first = step && !second_half_ff && ready_now;
   assign complete  = step && second_half_ff && !ready_now;
   assign pixel     = complete && (left_ff != '0);
   assign hi2       = work.port_status[7:3] ^ 5'h10;

   // assembled bytes for a finishing transfer
   always_comb begin
      if (cfg.bidir_mode) begin
         b0 = {held_ff[7], held_ff[6:0]};
         b1 = {held_ff[11:8], hi2[4:1]};
         b2 = {hi2[0], work.port_data[7:1]};
      end else begin
         b0 = {~held_ff[7], held_ff[6:4], ~work.port_status[7], work.port_status[6:4]};
         b1 = '0;
         b2 = '0;
      end
   end

   // next stage
   always_comb begin
      stage_in = stage_ff;
      if (work_pop && work.start) begin
         stage_in = cfnr_pkg::ST_RECV;
      end else if (complete && !pixel) begin
         if (cfg.bidir_mode) begin
            if (b2 != cfnr_pkg::PAD_BYTE) begin
               stage_in = cfnr_pkg::marker_check(b0, b1, b2);
            end
         end else if (tail_idx_ff != 2'd0 && tail_idx_ff != 2'd1) begin
            stage_in = cfnr_pkg::marker_check(tail_ff[15:8], tail_ff[7:0], b0);
         end
      end
   end

   // datapath and result
   always_comb begin
      second_half_in = second_half_ff;
      ack_in         = ack_ff;
      left_in        = left_ff;
      held_in        = held_ff;
      tail_in        = tail_ff;
      tail_idx_in    = tail_idx_ff;
      if (work_pop && work.start) begin
         second_half_in = 1'b0;
         ack_in         = 1'b0;
         left_in        = cfg.transfer_count;
         held_in        = '0;
         tail_in        = '0;
         tail_idx_in    = '0;
      end else if (take_first) begin
         held_in = cfg.bidir_mode ? {hi2, work.port_data[7:1]}
                                  : {4'h0, work.port_status[7:4], 4'h0};
         ack_in         = 1'b1;
         second_half_in = 1'b1;
      end else if (complete) begin
         ack_in         = 1'b0;
         second_half_in = 1'b0;
         if (pixel) begin
            left_in = left_ff - 1'b1;
         end else if (!cfg.bidir_mode) begin
            case (tail_idx_ff)
               2'd0: begin
                  if (b0 != cfnr_pkg::PAD_BYTE) begin
                     tail_in     = {b0, 8'h00};
                     tail_idx_in = 2'd1;
                  end
               end
               2'd1: begin
                  tail_in     = {tail_ff[15:8], b0};
                  tail_idx_in = 2'd2;
               end
               default: tail_idx_in = 2'd0;
            endcase
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (work_pop) begin
         rsp_valid_in          = 1'b1;
         rsp_in.ack_level      = ack_in;
         rsp_in.byte_count     = pixel ? (cfg.bidir_mode ? 2'd3 : 2'd1) : 2'd0;
         rsp_in.byte_first     = pixel ? b0 : 8'h00;
         rsp_in.byte_second    = pixel ? b1 : 8'h00;
         rsp_in.byte_third     = pixel ? b2 : 8'h00;
         rsp_in.frame_status   = stage_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= cfnr_pkg::ST_IDLE;
         second_half_ff <= 1'b0;
         ack_ff         <= 1'b1;
         left_ff        <= '0;
         held_ff        <= '0;
         tail_ff        <= '0;
         tail_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_ff       <= stage_in;
         second_half_ff <= second_half_in;
         ack_ff         <= ack_in;
         left_ff        <= left_in;
         held_ff        <= held_in;
         tail_ff        <= tail_in;
         tail_idx_ff    <= tail_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* src/camera_frame_nibble_receiver.sv */
`timescale 1ns / 1ps

// Host-side frame readout receiver for a camera on a parallel port. Each req_ word is
// either a start command or one sample of the port data and status lines; every word
// returns exactly one rsp_ word carrying the acknowledge level to drive, up to three
// assembled frame bytes and the frame status. The block sustains one word per clock
// when nothing stalls; the back end updates the handshake state as it pops a sample,
// and a two-entry queue plus the output register let the input and result sides stall
// independently. An accepted word passes through the queue, then the output register.
// bidir_mode is read on every sample; transfer_count is latched at a start command.

module camera_frame_nibble_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cfnr_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cfnr_pkg::rsp_type                   rsp_item,
   input  logic                                csr_wr_en,
   input  logic [cfnr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cfnr_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   cfnr_pkg::cfg_type  cfg_ff, cfg_in;
   cfnr_pkg::work_type front_word;
   cfnr_pkg::work_type queue_word;
   logic               queue_full;
   logic               queue_has;
   logic               queue_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cfnr_pkg::CSR_BIDIR_MODE:     cfg_in.bidir_mode = csr_data[0];
            cfnr_pkg::CSR_TRANSFER_COUNT: cfg_in.transfer_count = csr_data[cfnr_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bidir_mode     <= 1'b0;
         cfg_ff.transfer_count <= cfnr_pkg::TRANSFER_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;

   cfnr_front u_front (
      .req_item (req_item),
      .work     (front_word)
   );

   cfnr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_word (front_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_has),
      .pop_word  (queue_word)
   );

   cfnr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (queue_has),
      .work       (queue_word),
      .work_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
